/* rtl/core/csbd_pkg.sv */
// Shared types, constants and helpers for the clipped sprite blitter.
`timescale 1ns / 1ps

package csbd_pkg;

    localparam int DEF_FRAME_WIDTH  = 256;
    localparam int DEF_FRAME_HEIGHT = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int COLOR_W    = 16;
    localparam int DEPTH_W    = 8;
    localparam int COORD_W    = 12;
    localparam int CNT_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int ZSTEP_W    = 9;
    localparam int ZPROD_W    = ZSTEP_W + COORD_W;
    localparam int MAX_SIZE   = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X     = 3'd0,
        REG_DEST_Y     = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_SRC_HEIGHT = 3'd3,
        REG_BLIT_OP    = 3'd4,
        REG_MIRROR     = 3'd5,
        REG_Z_BASE     = 3'd6,
        REG_Z_STEP     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_COPY  = 2'd1,
        OP_ZBLND = 2'd2,
        OP_ROWZ  = 2'd3
    } blit_op_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } store_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  dest_x;
        logic [SIZE_W-1:0]  dest_y;
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  src_height;
        blit_op_t           blit_op;
        logic               mirror;
        logic [DEPTH_W-1:0] z_base;
        logic [ZSTEP_W-1:0] z_step;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
    } pixel_t;

    // One mapped sprite pixel on its way to the read-modify-write stage
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               in_frame;
        logic               last;
        pixel_t             pix;
        logic [ZPROD_W-1:0] zprod;
    } map_t;

    // Zero means one, anything above the maximum means the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(MAX_SIZE))
        begin
            r = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/csbd_cfg_if.sv */
// Configuration write channel.
`timescale 1ns / 1ps

interface csbd_cfg_if import csbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/csbd_pix_if.sv */
// Sprite pixel input channel.
`timescale 1ns / 1ps

interface csbd_pix_if import csbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               start_of_blit;
    logic [COLOR_W-1:0] pix_color;
    logic [DEPTH_W-1:0] pix_depth;

    modport source (output valid, output start_of_blit, output pix_color, output pix_depth,
                    input ready);
    modport sink   (input valid, input start_of_blit, input pix_color, input pix_depth,
                    output ready);
endinterface

/* rtl/core/csbd_res_if.sv */
// Blit result output channel.
`timescale 1ns / 1ps

interface csbd_res_if import csbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] frame_col;
    logic signed [COORD_W-1:0] frame_row;
    logic                      inside_frame;
    logic                      written;
    logic [COLOR_W-1:0]        stored_color;
    logic [DEPTH_W-1:0]        stored_depth;
    logic                      last_pixel;

    modport source (output valid, output frame_col, output frame_row, output inside_frame,
                    output written, output stored_color, output stored_depth,
                    output last_pixel, input ready);
    modport sink   (input valid, input frame_col, input frame_row, input inside_frame,
                    input written, input stored_color, input stored_depth,
                    input last_pixel, output ready);
endinterface

/* rtl/core/csbd_cfg_regs.sv */
// Configuration register file.
`timescale 1ns / 1ps

module csbd_cfg_regs import csbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    csbd_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_DEST_X:     cfg_next.dest_x     = cfg.data;
                REG_DEST_Y:     cfg_next.dest_y     = cfg.data;
                REG_SRC_WIDTH:  cfg_next.src_width  = cfg.data;
                REG_SRC_HEIGHT: cfg_next.src_height = cfg.data;
                REG_BLIT_OP:    cfg_next.blit_op    = blit_op_t'(cfg.data[1:0]);
                REG_MIRROR:     cfg_next.mirror     = cfg.data[0];
                REG_Z_BASE:     cfg_next.z_base     = cfg.data[DEPTH_W-1:0];
                REG_Z_STEP:     cfg_next.z_step     = cfg.data[ZSTEP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{dest_x:     '0,
                         dest_y:     '0,
                         src_width:  SIZE_W'(1),
                         src_height: SIZE_W'(1),
                         blit_op:    OP_DRAW,
                         mirror:     1'b0,
                         z_base:     '0,
                         z_step:     '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/csbd_addr_gen.sv */
// Sprite position counters and mapping of a pixel to its frame address.
`timescale 1ns / 1ps

module csbd_addr_gen import csbd_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
    parameter int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               accept,
    input  logic               start_of_blit,
    input  logic [COLOR_W-1:0] pix_color,
    input  logic [DEPTH_W-1:0] pix_depth,
    output map_t               map,
    output logic [ADDR_W-1:0]  addr
);

    logic [CNT_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [SIZE_W-1:0]  w, h;
    logic [CNT_W-1:0]   c0, r0, c, r;
    logic [SIZE_W-1:0]  c_inc, r_inc;
    logic [SIZE_W-1:0]  mir_offs;
    logic [CNT_W-1:0]   offs;
    logic [COORD_W-1:0] col, row, zdiff;
    logic               col_in, row_in;
    logic [21:0]        lin;
    logic signed [ZPROD_W-1:0] zprod;

    assign w  = clamp_size(cfg.src_width);
    assign h  = clamp_size(cfg.src_height);
    assign c0 = start_of_blit ? '0 : col_cnt_reg;
    assign r0 = start_of_blit ? '0 : row_cnt_reg;
    // counter left beyond a lowered size restarts at zero
    assign c  = ({1'b0, c0} < w) ? c0 : '0;
    assign r  = ({1'b0, r0} < h) ? r0 : '0;

    assign mir_offs = w - SIZE_W'(1) - {1'b0, c};
    assign offs     = (cfg.mirror && (cfg.blit_op == OP_DRAW || cfg.blit_op == OP_COPY))
                      ? mir_offs[CNT_W-1:0] : c;

    assign col = {cfg.dest_x[SIZE_W-1], cfg.dest_x} + {2'b00, offs};
    assign row = {cfg.dest_y[SIZE_W-1], cfg.dest_y} + {2'b00, r};

    assign col_in = !col[COORD_W-1] && (col[SIZE_W-1:0] < SIZE_W'(FRAME_WIDTH));
    assign row_in = !row[COORD_W-1] && (row[SIZE_W-1:0] < SIZE_W'(FRAME_HEIGHT));

    assign lin  = 22'(row[SIZE_W-1:0]) * 22'(FRAME_WIDTH) + 22'(col[SIZE_W-1:0]);
    assign addr = lin[ADDR_W-1:0];

    // rows since the first visible one
    assign zdiff = cfg.dest_y[SIZE_W-1] ? row : {2'b00, r};
    assign zprod = $signed(cfg.z_step) * $signed(zdiff);

    always_comb
    begin
        map.col      = col;
        map.row      = row;
        map.in_frame = col_in && row_in;
        map.last     = ({1'b0, c} == w - SIZE_W'(1)) && ({1'b0, r} == h - SIZE_W'(1));
        map.pix      = '{color: pix_color, depth: pix_depth};
        map.zprod    = zprod;
    end

    always_comb
    begin
        c_inc        = {1'b0, c} + SIZE_W'(1);
        r_inc        = {1'b0, r} + SIZE_W'(1);
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (c_inc >= w)
            begin
                col_cnt_next = '0;
                row_cnt_next = (r_inc >= h) ? '0 : r_inc[CNT_W-1:0];
            end
            else
            begin
                col_cnt_next = c_inc[CNT_W-1:0];
                row_cnt_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

/* rtl/core/csbd_frame_store.sv */
// Frame store memory (color and depth) with its clearing pass after reset.
`timescale 1ns / 1ps

module csbd_frame_store import csbd_pkg::*;
#(
    parameter int DEPTH  = DEF_FRAME_WIDTH * DEF_FRAME_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pixel_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    output logic              ready
);

    pixel_t             mem [DEPTH];
    pixel_t             rd_data_reg;
    store_state_t       state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               we;
    logic [ADDR_W-1:0]  wa;
    pixel_t             wd;

    assign ready   = (state_reg == ST_RUN);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        we            = wr_en;
        wa            = wr_addr;
        wd            = wr_data;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                wa            = clr_addr_reg;
                wd            = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/clipped_sprite_blit_with_depth_unit.sv */
// Top level of the clipped sprite blitter with depth test.
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------------
//  cfg     | in  | index (register 0..7), data (11 bit, low bits used)
//  pix     | in  | start_of_blit, pix_color, pix_depth
//  res     | out | frame_col, frame_row, inside_frame, written, stored_color,
//          |     | stored_depth, last_pixel
//
// One pixel per clock sustained while res takes its beats; an accepted beat
// is read from memory, then read-modify-written into the output register.
// After reset the frame store is cleared one entry per cycle, with
// pix.ready low until the clearing pass is done.
// A stalled res side holds the pipeline; pix.ready stays high while the
// output register is free or being drained.
`timescale 1ns / 1ps

module clipped_sprite_blit_with_depth_unit import csbd_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    csbd_cfg_if.sink    cfg,
    csbd_pix_if.sink    pix,
    csbd_res_if.source  res
);

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    cfg_t               regs;
    map_t               s0_map;
    logic [ADDR_W-1:0]  s0_addr;
    logic               store_ready;
    logic               accept;
    logic               out_free;

    // read stage -> modify stage
    logic               s1_valid_reg, s1_valid_next;
    map_t               s1_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    pixel_t             rd_data;

    // last write, forwarded over a read that raced it
    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    pixel_t             lw_data_reg;

    pixel_t             old_pix;
    pixel_t             new_pix;
    pixel_t             stored;
    logic               wr;
    logic               do_write;
    logic signed [ZPROD_W:0] zsum;
    logic [DEPTH_W-1:0] zsat;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;
    logic               out_inside_reg, out_written_reg, out_last_reg;
    pixel_t             out_pix_reg;

    csbd_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    csbd_addr_gen #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_addr_gen
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (regs),
        .accept        (accept),
        .start_of_blit (pix.start_of_blit),
        .pix_color     (pix.pix_color),
        .pix_depth     (pix.pix_depth),
        .map           (s0_map),
        .addr          (s0_addr)
    );

    csbd_frame_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (s0_addr),
        .rd_data (rd_data),
        .wr_en   (do_write),
        .wr_addr (s1_addr_reg),
        .wr_data (new_pix),
        .ready   (store_ready)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign pix.ready = store_ready && (!s1_valid_reg || out_free);
    assign accept    = pix.valid && pix.ready;

    // stored entry as of now: memory data, unless the write just before the read hit it
    assign old_pix = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rd_data;

    // row depth for row-depth blend, saturated to the depth range
    assign zsum = $signed({{(ZPROD_W - DEPTH_W + 1){1'b0}}, regs.z_base})
                + $signed({s1_reg.zprod[ZPROD_W-1], s1_reg.zprod});

    always_comb
    begin
        if (zsum < 0)
        begin
            zsat = '0;
        end
        else if (zsum > $signed((ZPROD_W + 1)'(255)))
        begin
            zsat = '1;
        end
        else
        begin
            zsat = zsum[DEPTH_W-1:0];
        end
    end

    always_comb
    begin
        new_pix.color = s1_reg.pix.color;
        new_pix.depth = (regs.blit_op == OP_ROWZ) ? zsat : s1_reg.pix.depth;
        unique case (regs.blit_op)
            OP_DRAW:  wr = (s1_reg.pix.color != '0);
            OP_COPY:  wr = 1'b1;
            OP_ZBLND: wr = (s1_reg.pix.color != '0) && (old_pix.depth <= s1_reg.pix.depth);
            OP_ROWZ:  wr = (s1_reg.pix.color != '0) && (old_pix.depth <= zsat);
            default:  wr = 1'b0;
        endcase
        wr = wr && s1_reg.in_frame;
        if (!s1_reg.in_frame)
        begin
            stored = '0;
        end
        else if (wr)
        begin
            stored = new_pix;
        end
        else
        begin
            stored = old_pix;
        end
    end

    assign do_write = s1_valid_reg && out_free && wr;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (do_write)
            begin
                lw_valid_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg      <= s0_map;
            s1_addr_reg <= s0_addr;
        end
        if (do_write)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= new_pix;
        end
        if (out_free && s1_valid_reg)
        begin
            out_col_reg     <= s1_reg.col;
            out_row_reg     <= s1_reg.row;
            out_inside_reg  <= s1_reg.in_frame;
            out_written_reg <= wr;
            out_last_reg    <= s1_reg.last;
            out_pix_reg     <= stored;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.frame_col    = out_col_reg;
    assign res.frame_row    = out_row_reg;
    assign res.inside_frame = out_inside_reg;
    assign res.written      = out_written_reg;
    assign res.stored_color = out_pix_reg.color;
    assign res.stored_depth = out_pix_reg.depth;
    assign res.last_pixel   = out_last_reg;

endmodule
